### rtl/pds_pkg.sv
// pds_pkg: widths, constants and shared types for the PLL divider search.
// No dependencies; imported by every module under rtl/.
`timescale 1ns / 1ps
package pds_pkg;

  localparam int unsigned REF_W = 20;
  localparam int unsigned FB_W  = 8;
  localparam int unsigned PD_W  = 3;
  localparam int unsigned N_W   = 25;   // target * 2 * pd, pd up to 15
  localparam int unsigned X_W   = 28;   // ref * fb and ref << 8
  localparam int unsigned B_W   = 21;   // tolerance bounds
  localparam int unsigned Y_W   = 27;   // target * 101
  localparam int unsigned M_W   = 28;
  localparam int unsigned P_W   = Y_W + M_W;

  localparam logic [REF_W-1:0] REF_RESET   = REF_W'(100000);
  localparam logic [FB_W-1:0]  FB_FALLBACK = FB_W'(150);
  localparam logic [PD_W-1:0]  PD_FALLBACK = PD_W'(1);
  localparam logic [6:0]       TOL_LO_NUM  = 7'd99;
  localparam logic [6:0]       TOL_HI_NUM  = 7'd101;
  // ceil(2^34 / 100); exact floor(y / 100) for y < 2^27
  localparam logic [M_W-1:0]   RECIP_100   = M_W'(171798692);
  localparam int unsigned      RECIP_SHIFT = 34;

  localparam int unsigned LAT = 8;      // length of the valid shift register that carries start to done

  typedef struct packed {
    logic            hit;
    logic [FB_W-1:0] fb;
  } lane_res_t;

endpackage

### rtl/pds_bounds.sv
// pds_bounds: floor(target*99/100) and floor(target*101/100), two stages.
// Depends on pds_pkg.
`timescale 1ns / 1ps
module pds_bounds (
  input  logic                     clk,
  input  logic [pds_pkg::REF_W-1:0] target,
  output logic [pds_pkg::B_W-1:0]   lo,
  output logic [pds_pkg::B_W-1:0]   hi
);
  import pds_pkg::*;

  logic [Y_W-1:0] y_lo;
  logic [Y_W-1:0] y_hi;
  logic [P_W-1:0] p_lo;
  logic [P_W-1:0] p_hi;

  assign p_lo = P_W'(y_lo) * P_W'(RECIP_100);
  assign p_hi = P_W'(y_hi) * P_W'(RECIP_100);

  always_ff @(posedge clk) begin
    y_lo <= Y_W'(target) * Y_W'(TOL_LO_NUM);
    y_hi <= Y_W'(target) * Y_W'(TOL_HI_NUM);
    lo   <= p_lo[RECIP_SHIFT +: B_W];
    hi   <= p_hi[RECIP_SHIFT +: B_W];
  end

endmodule

### rtl/pds_lane.sv
// pds_lane: one post divider: range check, 8-bit restoring divide over
// four stages, then reference*fb against the tolerance window. Uses pds_pkg.
`timescale 1ns / 1ps
module pds_lane #(
  parameter int unsigned PD = 1
) (
  input  logic                      clk,
  input  logic [pds_pkg::REF_W-1:0] target,
  input  logic [pds_pkg::REF_W-1:0] ref_khz,
  input  logic [pds_pkg::B_W-1:0]   lo,
  input  logic [pds_pkg::B_W-1:0]   hi,
  output pds_pkg::lane_res_t        res
);
  import pds_pkg::*;

  localparam int unsigned NSTG = 4;
  localparam logic [4:0]  D = 5'(2 * PD);

  logic [N_W-1:0]   n0;
  logic             ok0;
  logic [N_W-1:0]   n1;
  logic             ok1;
  logic [REF_W-1:0] r1;

  logic [N_W-1:0]   rem_q [NSTG];
  logic [FB_W-1:0]  q_q   [NSTG];
  logic [REF_W-1:0] r_q   [NSTG];
  logic             ok_q  [NSTG];

  logic [X_W-1:0]   blo_q [NSTG];
  logic [X_W-1:0]   bhi_q [NSTG];

  logic [X_W-1:0]   x6;
  logic [FB_W-1:0]  fb6;
  logic             ok6;

  assign n0  = N_W'(target) * N_W'(D);
  assign ok0 = (ref_khz != '0) && (X_W'(n0) >= {4'b0, ref_khz, 4'b0})
               && (X_W'(n0) < {ref_khz, 8'b0});

  always_ff @(posedge clk) begin
    n1  <= n0;
    ok1 <= ok0;
    r1  <= ref_khz;
  end

  for (genvar k = 0; k < NSTG; k++) begin : g_div
    logic [N_W-1:0]   rem_in;
    logic [FB_W-1:0]  q_in;
    logic [REF_W-1:0] r_in;
    logic             ok_in;
    logic [X_W-1:0]   sh_a;
    logic [X_W-1:0]   sh_b;
    logic [N_W-1:0]   rem_a;
    logic [N_W-1:0]   rem_b;
    logic [FB_W-1:0]  q_a;
    logic [FB_W-1:0]  q_b;

    if (k == 0) begin : g_first
      assign rem_in = n1;
      assign q_in   = '0;
      assign r_in   = r1;
      assign ok_in  = ok1;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign q_in   = q_q[k-1];
      assign r_in   = r_q[k-1];
      assign ok_in  = ok_q[k-1];
    end

    always_comb begin
      sh_a  = X_W'(r_in) << (7 - 2 * k);
      rem_a = rem_in;
      q_a   = q_in;
      if (X_W'(rem_in) >= sh_a) begin
        rem_a = rem_in - N_W'(sh_a);
        q_a[7-2*k] = 1'b1;
      end
      sh_b  = X_W'(r_in) << (6 - 2 * k);
      rem_b = rem_a;
      q_b   = q_a;
      if (X_W'(rem_a) >= sh_b) begin
        rem_b = rem_a - N_W'(sh_b);
        q_b[6-2*k] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      rem_q[k] <= rem_b;
      q_q[k]   <= q_b;
      r_q[k]   <= r_in;
      ok_q[k]  <= ok_in;
    end
  end

  // bounds arrive with the first divide stage; scaled by 2*pd
  always_ff @(posedge clk) begin
    blo_q[0] <= X_W'(X_W'(lo) + X_W'(1)) * X_W'(D);
    bhi_q[0] <= X_W'(hi) * X_W'(D);
    for (int i = 1; i < NSTG; i++) begin
      blo_q[i] <= blo_q[i-1];
      bhi_q[i] <= bhi_q[i-1];
    end
  end

  always_ff @(posedge clk) begin
    x6  <= X_W'(r_q[NSTG-1]) * X_W'(q_q[NSTG-1]);
    fb6 <= q_q[NSTG-1];
    ok6 <= ok_q[NSTG-1];
    res.hit <= ok6 && (x6 >= blo_q[NSTG-1]) && (x6 < bhi_q[NSTG-1]);
    res.fb  <= fb6;
  end

endmodule

### rtl/pll_divider_search_core.sv
// pll_divider_search_core: top level of the PLL divider search pipeline.
// Depends on pds_pkg, pds_bounds and pds_lane.
//
// channel   ports                                         handshake
// config    cfg_write, cfg_data                           write when cfg_write
// request   start, busy, request_khz                      start && !busy
// result    done, feedback_divider, post_divider, found   one-cycle done strobe
//
// One transaction per cycle; done rises together with the registered result of its request.
// The pipeline holds input registers, the four-stage divider in each lane, bounds and checks.
// busy stays low; the pipeline never stalls and the receiver cannot stall.
// rst is synchronous; it clears valid bits and sets reference_khz to 100000.
`timescale 1ns / 1ps
module pll_divider_search_core #(
  parameter int unsigned MAX_POST_DIVIDER = 7
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [pds_pkg::REF_W-1:0] cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic [pds_pkg::REF_W-1:0] request_khz,
  output logic                      done,
  output logic [pds_pkg::FB_W-1:0]  feedback_divider,
  output logic [pds_pkg::PD_W-1:0]  post_divider,
  output logic                      found
);
  import pds_pkg::*;

  logic [REF_W-1:0] reference_khz;
  logic [REF_W-1:0] t0;
  logic [REF_W-1:0] r0;
  logic [LAT-1:0]   vld;
  logic [B_W-1:0]   lo;
  logic [B_W-1:0]   hi;
  lane_res_t        lane_res [1:MAX_POST_DIVIDER];
  logic [FB_W-1:0]  fb_next;
  logic [PD_W-1:0]  pd_next;
  logic             found_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_khz <= REF_RESET;
      vld           <= '0;
      done          <= 1'b0;
    end else begin
      if (cfg_write) begin
        reference_khz <= cfg_data;
      end
      vld  <= {vld[LAT-2:0], start};
      done <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    t0 <= request_khz;
    r0 <= reference_khz;
  end

  pds_bounds u_bounds (
    .clk    (clk),
    .target (t0),
    .lo     (lo),
    .hi     (hi)
  );

  for (genvar g = 1; g <= MAX_POST_DIVIDER; g++) begin : g_lane
    pds_lane #(.PD(g)) u_lane (
      .clk     (clk),
      .target  (t0),
      .ref_khz (r0),
      .lo      (lo),
      .hi      (hi),
      .res     (lane_res[g])
    );
  end

  always_comb begin
    fb_next    = FB_FALLBACK;
    pd_next    = PD_FALLBACK;
    found_next = 1'b0;
    for (int l = MAX_POST_DIVIDER; l >= 1; l--) begin
      if (lane_res[l].hit) begin
        fb_next    = lane_res[l].fb;
        pd_next    = PD_W'(l);
        found_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    feedback_divider <= fb_next;
    post_divider     <= pd_next;
    found            <= found_next;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##9 done) else $error("result strobe missing");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 9)) else $error("result without transaction");
  a_fallback: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> (feedback_divider == FB_FALLBACK && post_divider == PD_FALLBACK))
    else $error("bad fallback");
  a_fb_range: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (feedback_divider >= FB_W'(16)))
    else $error("feedback divider out of range");
`endif

endmodule
